>>> sv/frd_pkg.sv
// shared types and constants of the record deframer
package frd_pkg;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_REC_END = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
   localparam logic [2:0] ST_DUPLICATE    = 3'd2;
   localparam logic [2:0] ST_BAD_ROLE     = 3'd3;
   localparam logic [2:0] ST_SHORT_BODY   = 3'd4;
   localparam logic [2:0] ST_TABLE_FULL   = 3'd5;
   localparam logic [2:0] ST_RELEASE_MISS = 3'd6;

   localparam logic [2:0] SPH_NEW         = 3'd0;
   localparam logic [2:0] SPH_PARAMS      = 3'd1;
   localparam logic [2:0] SPH_PARAMS_DONE = 3'd2;
   localparam logic [2:0] SPH_STDIN       = 3'd3;
   localparam logic [2:0] SPH_STDIN_DONE  = 3'd4;

   localparam logic [7:0]  T_BEGIN        = 8'd1;
   localparam logic [7:0]  T_PARAMS       = 8'd4;
   localparam logic [7:0]  T_STDIN        = 8'd5;
   localparam logic [15:0] ROLE_RESPONDER = 16'd1;
   localparam logic [15:0] BEGIN_BODY_MIN = 16'd8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_CONTENT,
      PARSE_PADDING
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  rec_type;
      logic [15:0] record_id;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic [2:0]  slot;
      logic [2:0]  phase;
      logic        last;
   } rsp_item_type;

endpackage

>>> sv/frd_if.sv
// request and response channel interfaces of the record deframer
interface frd_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  in_byte;
   logic [15:0] release_id;

   modport source (output valid, operation, in_byte, release_id, input ready);
   modport sink (input valid, operation, in_byte, release_id, output ready);
endinterface

interface frd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  rec_type;
   logic [15:0] record_id;
   logic [7:0]  data_byte;
   logic [2:0]  status;
   logic [2:0]  slot;
   logic [2:0]  phase;
   logic        last;

   modport source (output valid, result_kind, rec_type, record_id, data_byte, status, slot,
                   phase, last, input ready);
   modport sink (input valid, result_kind, rec_type, record_id, data_byte, status, slot,
                 phase, last, output ready);
endinterface

>>> sv/frd_rsp_queue.sv
// result queue taking up to two results per cycle and giving one per transfer
module frd_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push0,
   input  logic                 push1,
   input  frd_pkg::rsp_item_type item0,
   input  frd_pkg::rsp_item_type item1,
   output logic                 room,
   output logic                 out_valid,
   output frd_pkg::rsp_item_type out_item,
   input  logic                 out_ready
);

   frd_pkg::rsp_item_type mem_ff [frd_pkg::QUEUE_DEPTH];
   logic [frd_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [frd_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [frd_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic [frd_pkg::QUEUE_AW:0]   push_n;
   logic                         pop;

   assign pop       = out_valid & out_ready;
   assign push_n    = {{frd_pkg::QUEUE_AW{1'b0}}, push0} + {{frd_pkg::QUEUE_AW{1'b0}}, push1};
   assign count_in  = count_ff + push_n - {{frd_pkg::QUEUE_AW{1'b0}}, pop};
   assign wr_ptr_in = wr_ptr_ff + push_n[frd_pkg::QUEUE_AW-1:0];
   assign rd_ptr_in = rd_ptr_ff + {{(frd_pkg::QUEUE_AW-1){1'b0}}, pop};

   assign room      = count_ff <= (frd_pkg::QUEUE_AW+1)'(frd_pkg::QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= item0;
      end
      if (push1) begin
         mem_ff[wr_ptr_ff + {{(frd_pkg::QUEUE_AW-1){1'b0}}, 1'b1}] <= item1;
      end
   end

endmodule

>>> sv/fastcgi_record_deframer.sv
// FastCGI record deframer top level
// Takes one stream byte or one release request per cycle. Each transfer is parsed in the
// cycle it arrives: the header fields, the content and padding counters and the request table
// (SLOTS entries, matched by a parallel compare of all ids) are updated at once, and the 0, 1
// or 2 results it causes go into a four-entry result queue that returns one result per
// transfer and offers them in order behind any results still queued. The request
// side stays ready while two queue entries are free, so one byte per cycle is sustained as
// long as the result side keeps up; a forwarded byte that ends its record puts two
// results in the queue. Request id zero never matches a slot.
module fastcgi_record_deframer #(
   parameter int SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   frd_req_if.sink      req_chan,
   frd_rsp_if.source    rsp_chan
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [2:0] HDR_TYPE   = 3'd1;
   localparam logic [2:0] HDR_ID_HI  = 3'd2;
   localparam logic [2:0] HDR_ID_LO  = 3'd3;
   localparam logic [2:0] HDR_LEN_HI = 3'd4;
   localparam logic [2:0] HDR_LEN_LO = 3'd5;
   localparam logic [2:0] HDR_PAD    = 3'd6;
   localparam logic [2:0] HDR_LAST   = 3'd7;

   frd_pkg::parse_phase_type parse_ff, parse_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [15:0] cur_req_ff, cur_req_in;
   logic [15:0] content_size_ff, content_size_in;
   logic [7:0]  padding_size_ff, padding_size_in;
   logic [16:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0] begin_role_ff, begin_role_in;

   logic [SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [15:0]      slot_id_ff [SLOTS];
   logic [2:0]       slot_phase_ff [SLOTS];

   logic              accept, is_release, stream_step;
   logic [15:0]       key;
   logic [SLOTS-1:0]  hit;
   logic              hit_any, free_any;
   logic [SLOT_W-1:0] hit_idx, free_idx;
   logic [2:0]        hit_slot3, free_slot3, hit_phase;
   logic [16:0]       bytes_inc, pad_total;
   logic              rec_end, in_content;

   logic [2:0] e_status, e_slot, e_phase, new_phase;
   logic       e_alloc, e_update, alloc_we, update_we, fwd;

   logic                  push0, push1, room;
   frd_pkg::rsp_item_type item0, item1, out_item;

   assign req_chan.ready = room;
   assign accept      = req_chan.valid & req_chan.ready;
   assign is_release  = req_chan.operation == frd_pkg::OP_RELEASE;
   assign stream_step = accept & ~is_release;
   assign key         = is_release ? req_chan.release_id : cur_req_ff;

   // table lookup and free slot search
   always_comb begin
      hit      = '0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit[i] = slot_valid_ff[i] && (slot_id_ff[i] == key) && (key != 16'd0);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign hit_any    = |hit;
   assign free_any   = ~&slot_valid_ff;
   assign hit_slot3  = 3'(hit_idx);
   assign free_slot3 = 3'(free_idx);
   assign hit_phase  = slot_phase_ff[hit_idx];

   assign bytes_inc = bytes_seen_ff + 17'd1;
   assign pad_total = {1'b0, content_size_ff} + {9'd0, padding_size_ff};

   // parse next state
   always_comb begin
      parse_in        = parse_ff;
      hdr_idx_in      = hdr_idx_ff;
      cur_type_in     = cur_type_ff;
      cur_req_in      = cur_req_ff;
      content_size_in = content_size_ff;
      padding_size_in = padding_size_ff;
      bytes_seen_in   = bytes_seen_ff;
      begin_role_in   = begin_role_ff;
      rec_end         = 1'b0;
      in_content      = 1'b0;
      case (parse_ff)
         frd_pkg::PARSE_CONTENT: begin
            in_content = 1'b1;
            if (cur_type_ff == frd_pkg::T_BEGIN) begin
               if (bytes_seen_ff == 17'd0) begin
                  begin_role_in[15:8] = req_chan.in_byte;
               end else if (bytes_seen_ff == 17'd1) begin
                  begin_role_in[7:0] = req_chan.in_byte;
               end
            end
            bytes_seen_in = bytes_inc;
            if (bytes_inc >= {1'b0, content_size_ff}) begin
               if (padding_size_ff != 8'd0) begin
                  parse_in = frd_pkg::PARSE_PADDING;
               end else begin
                  rec_end    = 1'b1;
                  parse_in   = frd_pkg::PARSE_HEADER;
                  hdr_idx_in = 3'd0;
               end
            end
         end
         frd_pkg::PARSE_PADDING: begin
            bytes_seen_in = bytes_inc;
            if (bytes_inc >= pad_total) begin
               rec_end    = 1'b1;
               parse_in   = frd_pkg::PARSE_HEADER;
               hdr_idx_in = 3'd0;
            end
         end
         default: begin
            case (hdr_idx_ff)
               HDR_TYPE:   cur_type_in = req_chan.in_byte;
               HDR_ID_HI:  cur_req_in[15:8] = req_chan.in_byte;
               HDR_ID_LO:  cur_req_in[7:0] = req_chan.in_byte;
               HDR_LEN_HI: content_size_in[15:8] = req_chan.in_byte;
               HDR_LEN_LO: content_size_in[7:0] = req_chan.in_byte;
               HDR_PAD:    padding_size_in = req_chan.in_byte;
               default:    ;
            endcase
            if (hdr_idx_ff == HDR_LAST) begin
               hdr_idx_in    = 3'd0;
               bytes_seen_in = '0;
               begin_role_in = '0;
               if (content_size_ff != 16'd0) begin
                  parse_in = frd_pkg::PARSE_CONTENT;
               end else if (padding_size_ff != 8'd0) begin
                  parse_in = frd_pkg::PARSE_PADDING;
               end else begin
                  rec_end  = 1'b1;
                  parse_in = frd_pkg::PARSE_HEADER;
               end
            end else begin
               hdr_idx_in = hdr_idx_ff + 3'd1;
               parse_in   = frd_pkg::PARSE_HEADER;
            end
         end
      endcase
   end

   // record end checks
   always_comb begin
      e_status  = frd_pkg::ST_OK;
      e_slot    = 3'd0;
      e_phase   = frd_pkg::SPH_NEW;
      e_alloc   = 1'b0;
      e_update  = 1'b0;
      new_phase = hit_phase;
      if (cur_type_ff == frd_pkg::T_BEGIN) begin
         if (hit_any) begin
            e_status = frd_pkg::ST_DUPLICATE;
         end else if (cur_req_ff == 16'd0) begin
            e_status = frd_pkg::ST_NOT_FOUND;
         end else if (content_size_ff < frd_pkg::BEGIN_BODY_MIN) begin
            e_status = frd_pkg::ST_SHORT_BODY;
         end else if (begin_role_ff != frd_pkg::ROLE_RESPONDER) begin
            e_status = frd_pkg::ST_BAD_ROLE;
         end else if (free_any) begin
            e_alloc = 1'b1;
            e_slot  = free_slot3;
         end else begin
            e_status = frd_pkg::ST_TABLE_FULL;
         end
      end else if (!hit_any) begin
         e_status = frd_pkg::ST_NOT_FOUND;
      end else begin
         e_slot = hit_slot3;
         if (cur_type_ff == frd_pkg::T_PARAMS) begin
            e_update  = 1'b1;
            new_phase = (content_size_ff == 16'd0) ? frd_pkg::SPH_PARAMS_DONE
                                                   : frd_pkg::SPH_PARAMS;
         end else if (cur_type_ff == frd_pkg::T_STDIN) begin
            e_update  = 1'b1;
            new_phase = (content_size_ff == 16'd0) ? frd_pkg::SPH_STDIN_DONE
                                                   : frd_pkg::SPH_STDIN;
         end
         e_phase = new_phase;
      end
   end

   // results and table writes
   always_comb begin
      item0         = '0;
      item1         = '0;
      push0         = 1'b0;
      push1         = 1'b0;
      slot_valid_in = slot_valid_ff;
      alloc_we      = 1'b0;
      update_we     = 1'b0;
      fwd = in_content && hit_any &&
            ((cur_type_ff == frd_pkg::T_PARAMS) || (cur_type_ff == frd_pkg::T_STDIN));
      if (accept && is_release) begin
         push0             = 1'b1;
         item0.result_kind = frd_pkg::KIND_RELEASE;
         item0.record_id   = req_chan.release_id;
         item0.last        = 1'b1;
         if (hit_any) begin
            item0.status           = frd_pkg::ST_OK;
            item0.slot             = hit_slot3;
            item0.phase            = hit_phase;
            slot_valid_in[hit_idx] = 1'b0;
         end else begin
            item0.status = frd_pkg::ST_RELEASE_MISS;
         end
      end else if (stream_step) begin
         if (fwd) begin
            push0             = 1'b1;
            item0.result_kind = frd_pkg::KIND_CONTENT;
            item0.rec_type    = cur_type_ff;
            item0.record_id   = cur_req_ff;
            item0.data_byte   = req_chan.in_byte;
            item0.status      = frd_pkg::ST_OK;
            item0.slot        = hit_slot3;
            item0.phase       = (cur_type_ff == frd_pkg::T_PARAMS) ? frd_pkg::SPH_PARAMS
                                                                   : frd_pkg::SPH_STDIN;
            item0.last        = ~rec_end;
         end
         if (rec_end) begin
            alloc_we          = e_alloc;
            update_we         = e_update;
            item1.result_kind = frd_pkg::KIND_REC_END;
            item1.rec_type    = cur_type_ff;
            item1.record_id   = cur_req_ff;
            item1.status      = e_status;
            item1.slot        = e_slot;
            item1.phase       = e_phase;
            item1.last        = 1'b1;
            if (e_alloc) begin
               slot_valid_in[free_idx] = 1'b1;
            end
            if (fwd) begin
               push1 = 1'b1;
            end else begin
               push0 = 1'b1;
               item0 = item1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff      <= frd_pkg::PARSE_HEADER;
         hdr_idx_ff    <= 3'd0;
         slot_valid_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         if (stream_step) begin
            parse_ff   <= parse_in;
            hdr_idx_ff <= hdr_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stream_step) begin
         cur_type_ff     <= cur_type_in;
         cur_req_ff      <= cur_req_in;
         content_size_ff <= content_size_in;
         padding_size_ff <= padding_size_in;
         bytes_seen_ff   <= bytes_seen_in;
         begin_role_ff   <= begin_role_in;
      end
      if (alloc_we) begin
         slot_id_ff[free_idx]    <= cur_req_ff;
         slot_phase_ff[free_idx] <= frd_pkg::SPH_NEW;
      end
      if (update_we) begin
         slot_phase_ff[hit_idx] <= new_phase;
      end
   end

   frd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .item0     (item0),
      .item1     (item1),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_item  (out_item),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.result_kind = out_item.result_kind;
   assign rsp_chan.rec_type    = out_item.rec_type;
   assign rsp_chan.record_id   = out_item.record_id;
   assign rsp_chan.data_byte   = out_item.data_byte;
   assign rsp_chan.status      = out_item.status;
   assign rsp_chan.slot        = out_item.slot;
   assign rsp_chan.phase       = out_item.phase;
   assign rsp_chan.last        = out_item.last;

endmodule

>>> sv/frd_checker.sv
// port checker of the record deframer and its bind
module frd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_rec_type,
   input logic [7:0]  rsp_data_byte,
   input logic [2:0]  rsp_status,
   input logic [2:0]  rsp_phase,
   input logic        rsp_last
);

   // queue is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   a_release_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == frd_pkg::KIND_RELEASE)
      |-> rsp_last && (rsp_rec_type == 8'd0) && (rsp_data_byte == 8'd0))
      else $error("malformed release result");

   a_content_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == frd_pkg::KIND_CONTENT)
      |-> (rsp_status == frd_pkg::ST_OK) &&
          ((rsp_phase == frd_pkg::SPH_PARAMS) || (rsp_phase == frd_pkg::SPH_STDIN)))
      else $error("malformed content result");

endmodule

bind fastcgi_record_deframer frd_checker u_frd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_result_kind (rsp_chan.result_kind),
   .rsp_rec_type    (rsp_chan.rec_type),
   .rsp_data_byte   (rsp_chan.data_byte),
   .rsp_status      (rsp_chan.status),
   .rsp_phase       (rsp_chan.phase),
   .rsp_last        (rsp_chan.last)
);
